// ===== rtl/i3wf_pkg.sv =====
// shared types, constants and helpers of the 3x3 window filter
`default_nettype none
package i3wf_pkg;

  localparam int MaxLine    = 1024;
  localparam int MaxLines   = 1024;
  localparam int StoreDepth = 2 * MaxLine + 4;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int DimW       = 11;
  localparam int CntW       = 21;
  localparam int PixW       = 8;
  localparam int ValW       = 11;
  localparam int ModeW      = 2;
  localparam int CfgIdxW    = 2;
  localparam int QDepth     = 4;
  localparam int GradW      = 12;

  typedef enum logic [ModeW-1:0] {
    MODE_PASS  = 2'd0,
    MODE_MEAN  = 2'd1,
    MODE_GAUSS = 2'd2,
    MODE_SOBEL = 2'd3
  } mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_FILTER_MODE  = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_WRITE, BK_DIVPOS, BK_GATHER, BK_CALC, BK_DIVVAL, BK_OUT
  } bk_state_t;

  typedef struct packed {
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    mode_t           mode;
  } cfg_t;

  typedef struct packed {
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [PixW-1:0]  wr_data;
    logic             emit;
    logic             frame_end;
    logic [CntW-1:0]  pos;
    logic [AddrW-1:0] pos_addr;
    logic [DimW-1:0]  width;
    logic [DimW-1:0]  height;
    mode_t            mode;
  } job_t;

  localparam logic [2:0] GaussW [9] = '{3'd1, 3'd2, 3'd1, 3'd2, 3'd4, 3'd2, 3'd1, 3'd2, 3'd1};
  localparam logic signed [2:0] SobX [9] = '{3'sd1, 3'sd0, -3'sd1, 3'sd2, 3'sd0, -3'sd2,
                                             3'sd1, 3'sd0, -3'sd1};
  localparam logic signed [2:0] SobY [9] = '{3'sd1, 3'sd2, 3'sd1, 3'sd0, 3'sd0, 3'sd0,
                                             -3'sd1, -3'sd2, -3'sd1};

  // ring address step, wraps at the store depth
  function automatic logic [AddrW-1:0] addr_incr(input logic [AddrW-1:0] a);
    logic [AddrW-1:0] r;
    if (a == AddrW'(StoreDepth - 1)) r = '0;
    else r = a + 1'b1;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/i3wf_ifs.sv =====
// channel interfaces of the 3x3 window filter
`default_nettype none
interface i3wf_in_if;
  logic                      valid;
  logic                      ready;
  logic                      pixel_valid;
  logic [i3wf_pkg::PixW-1:0] pixel_value;
  modport source (output valid, pixel_valid, pixel_value, input ready);
  modport sink   (input valid, pixel_valid, pixel_value, output ready);
endinterface

interface i3wf_out_if;
  logic                      valid;
  logic                      ready;
  logic                      out_valid;
  logic [i3wf_pkg::ValW-1:0] out_value;
  logic                      out_frame_end;
  modport source (output valid, out_valid, out_value, out_frame_end, input ready);
  modport sink   (input valid, out_valid, out_value, out_frame_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/i3wf_front.sv =====
// front end: frame counters, store addressing and job classification
`default_nettype none
module i3wf_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  i3wf_in_if.sink            in_ch,
  input  wire i3wf_pkg::cfg_t cfg,
  output i3wf_pkg::job_t     push_data,
  output logic               push_valid,
  input  wire logic          push_ready
);
  import i3wf_pkg::*;

  logic [DimW-1:0]  w, h;
  logic [CntW-1:0]  total;
  logic [CntW-1:0]  ic_r, ic_nxt, oc_r, oc_nxt;
  logic [AddrW-1:0] ia_r, ia_nxt, oa_r, oa_nxt;
  logic             accept;
  job_t             job;

  always_comb begin
    if (cfg.width == '0) w = DimW'(1);
    else if (cfg.width > DimW'(MaxLine)) w = DimW'(MaxLine);
    else w = cfg.width;
    if (cfg.height == '0) h = DimW'(1);
    else if (cfg.height > DimW'(MaxLines)) h = DimW'(MaxLines);
    else h = cfg.height;
    total = CntW'(w) * CntW'(h);
  end

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign accept      = in_ch.valid && push_ready;
  assign push_data   = job;

  always_comb begin
    ic_nxt = ic_r;
    oc_nxt = oc_r;
    ia_nxt = ia_r;
    oa_nxt = oa_r;
    job    = '0;
    // leftover count from a shrunk geometry
    if (oc_nxt >= total) begin
      ic_nxt = '0;
      oc_nxt = '0;
      ia_nxt = '0;
      oa_nxt = '0;
    end
    if (in_ch.pixel_valid && ic_nxt < total) begin
      job.wr_en   = 1'b1;
      job.wr_addr = ia_nxt;
      job.wr_data = in_ch.pixel_value;
      ic_nxt      = ic_nxt + 1'b1;
      ia_nxt      = addr_incr(ia_nxt);
    end
    if (ic_nxt >= total ||
        {1'b0, ic_nxt} >= {1'b0, oc_nxt} + (CntW+1)'(w) + (CntW+1)'(2)) begin
      job.emit     = 1'b1;
      job.pos      = oc_nxt;
      job.pos_addr = oa_nxt;
      oc_nxt       = oc_nxt + 1'b1;
      oa_nxt       = addr_incr(oa_nxt);
      if (oc_nxt >= total) begin
        job.frame_end = 1'b1;
        ic_nxt = '0;
        oc_nxt = '0;
        ia_nxt = '0;
        oa_nxt = '0;
      end
    end
    job.width  = w;
    job.height = h;
    job.mode   = cfg.mode;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ic_r <= '0;
      oc_r <= '0;
      ia_r <= '0;
      oa_r <= '0;
    end else if (accept) begin
      ic_r <= ic_nxt;
      oc_r <= oc_nxt;
      ia_r <= ia_nxt;
      oa_r <= oa_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/i3wf_fifo.sv =====
// job queue between front and back
`default_nettype none
module i3wf_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire i3wf_pkg::job_t push_data,
  input  wire logic           push_valid,
  output logic                push_ready,
  output i3wf_pkg::job_t      pop_data,
  output logic                pop_valid,
  input  wire logic           pop_ready
);
  import i3wf_pkg::*;

  localparam int PtrW = $clog2(QDepth);

  job_t              q_r [QDepth];
  logic [PtrW-1:0]   wp_r, rp_r;
  logic [PtrW:0]     cnt_r;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != (PtrW+1)'(QDepth));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = q_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/i3wf_div.sv =====
// restoring serial divider, one quotient bit per cycle
`default_nettype none
module i3wf_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [i3wf_pkg::CntW-1:0]  dividend,
  input  wire logic [i3wf_pkg::DimW-1:0]  divisor,
  output logic                            done,
  output logic [i3wf_pkg::CntW-1:0]       quotient,
  output logic [i3wf_pkg::DimW-1:0]       remainder
);
  import i3wf_pkg::*;

  localparam int StepW = $clog2(CntW + 1);

  logic [CntW-1:0]  quo_r;
  logic [DimW-1:0]  rem_r, dvs_r;
  logic [StepW-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DimW:0]    sh;
  logic             fits;

  assign sh        = {rem_r, quo_r[CntW-1]};
  assign fits      = sh >= {1'b0, dvs_r};
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[CntW-2:0], fits};
      rem_r <= fits ? DimW'(sh - {1'b0, dvs_r}) : DimW'(sh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= StepW'(CntW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == StepW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/i3wf_back.sv =====
// back end: line store, window gather, filter arithmetic, result register
`default_nettype none
module i3wf_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire i3wf_pkg::job_t pop_data,
  input  wire logic           pop_valid,
  output logic                pop_ready,
  i3wf_out_if.source          out_ch
);
  import i3wf_pkg::*;

  bk_state_t state_r, state_nxt;
  job_t      job_r, job_nxt;

  logic [PixW-1:0] mem [StoreDepth];
  logic [PixW-1:0] rd_data_r;
  logic            rd_en;
  logic [AddrW-1:0] rd_addr;

  logic [DimW-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [1:0]      ki_r, ki_nxt, kj_r, kj_nxt;
  logic            pend_v_r, pend_v_nxt, pend_pres_r, pend_pres_nxt;
  logic [3:0]      pend_k_r, pend_k_nxt;
  logic [ValW-1:0] msum_r, msum_nxt;
  logic [3:0]      mn_r, mn_nxt;
  logic [GradW-1:0] gsum_r, gsum_nxt;
  logic [4:0]      gn_r, gn_nxt;
  logic signed [GradW-1:0] gx_r, gx_nxt, gy_r, gy_nxt;
  logic [PixW-1:0] center_r, center_nxt;
  logic [ValW-1:0] res_r, res_nxt;
  logic            res_emit_r, res_emit_nxt, res_end_r, res_end_nxt;

  logic            div_start, div_done;
  logic [CntW-1:0] div_dividend, div_quo;
  logic [DimW-1:0] div_divisor, div_rem;

  logic signed [GradW-1:0] rr, cc;
  logic signed [13:0]      roff, saddr;
  logic [3:0]              k_cur;
  logic                    pres;
  logic [PixW-1:0]         v;
  logic signed [GradW-1:0] vs, gx_abs, gy_abs;

  i3wf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // window tap under the gather counter
  always_comb begin
    k_cur = 4'({ki_r, 1'b0}) + 4'(ki_r) + 4'(kj_r);
    rr    = $signed(GradW'(row_r)) + $signed(GradW'(ki_r)) - GradW'(1);
    cc    = $signed(GradW'(col_r)) + $signed(GradW'(kj_r)) - GradW'(1);
    pres  = (rr >= 0) && (rr < $signed(GradW'(job_r.height))) &&
            (cc >= 0) && (cc < $signed(GradW'(job_r.width)));
    if (ki_r == 2'd0) roff = -$signed(14'(job_r.width));
    else if (ki_r == 2'd2) roff = $signed(14'(job_r.width));
    else roff = '0;
    saddr = $signed(14'(job_r.pos_addr)) + roff + $signed(14'(kj_r)) - 14'sd1;
    if (saddr < 0) saddr = saddr + 14'(StoreDepth);
    else if (saddr >= $signed(14'(StoreDepth))) saddr = saddr - 14'(StoreDepth);
    rd_addr = AddrW'(saddr);
  end

  always_comb begin
    v      = pend_pres_r ? rd_data_r : '0;
    vs     = $signed(GradW'(v));
    gx_abs = (gx_r < 0) ? -gx_r : gx_r;
    gy_abs = (gy_r < 0) ? -gy_r : gy_r;
  end

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    ki_nxt        = ki_r;
    kj_nxt        = kj_r;
    pend_v_nxt    = 1'b0;
    pend_pres_nxt = pend_pres_r;
    pend_k_nxt    = pend_k_r;
    msum_nxt      = msum_r;
    mn_nxt        = mn_r;
    gsum_nxt      = gsum_r;
    gn_nxt        = gn_r;
    gx_nxt        = gx_r;
    gy_nxt        = gy_r;
    center_nxt    = center_r;
    res_nxt       = res_r;
    res_emit_nxt  = res_emit_r;
    res_end_nxt   = res_end_r;
    pop_ready     = 1'b0;
    rd_en         = 1'b0;
    div_start     = 1'b0;
    div_dividend  = CntW'(job_r.pos);
    div_divisor   = job_r.width;
    out_ch.valid  = 1'b0;

    case (state_r)
      BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          job_nxt   = pop_data;
          state_nxt = BK_WRITE;
        end
      end
      BK_WRITE: begin
        res_emit_nxt = job_r.emit;
        res_end_nxt  = job_r.frame_end;
        res_nxt      = '0;
        if (job_r.emit) begin
          // split the position into row and column
          div_start = 1'b1;
          state_nxt = BK_DIVPOS;
        end else begin
          state_nxt = BK_OUT;
        end
      end
      BK_DIVPOS: begin
        if (div_done) begin
          row_nxt    = div_quo[DimW-1:0];
          col_nxt    = div_rem;
          ki_nxt     = '0;
          kj_nxt     = '0;
          msum_nxt   = '0;
          mn_nxt     = '0;
          gsum_nxt   = '0;
          gn_nxt     = '0;
          gx_nxt     = '0;
          gy_nxt     = '0;
          center_nxt = '0;
          state_nxt  = BK_GATHER;
        end
      end
      BK_GATHER: begin
        // fold in the tap read last cycle
        if (pend_v_r && pend_pres_r) begin
          if (pend_k_r == 4'd4) begin
            center_nxt = v;
          end else begin
            msum_nxt = msum_r + ValW'(v);
            mn_nxt   = mn_r + 1'b1;
          end
          gsum_nxt = gsum_r + GradW'(v) * GradW'(GaussW[pend_k_r]);
          gn_nxt   = gn_r + 5'(GaussW[pend_k_r]);
          gx_nxt   = gx_r + vs * GradW'(SobX[pend_k_r]);
          gy_nxt   = gy_r + vs * GradW'(SobY[pend_k_r]);
        end
        if (ki_r == 2'd3) begin
          state_nxt = BK_CALC;
        end else begin
          rd_en         = pres;
          pend_v_nxt    = 1'b1;
          pend_pres_nxt = pres;
          pend_k_nxt    = k_cur;
          if (kj_r == 2'd2) begin
            kj_nxt = '0;
            ki_nxt = ki_r + 1'b1;
          end else begin
            kj_nxt = kj_r + 1'b1;
          end
        end
      end
      BK_CALC: begin
        case (job_r.mode)
          MODE_MEAN: begin
            if (mn_r == '0) begin
              res_nxt   = ValW'(center_r);
              state_nxt = BK_OUT;
            end else begin
              div_start    = 1'b1;
              div_dividend = CntW'(msum_r);
              div_divisor  = DimW'(mn_r);
              state_nxt    = BK_DIVVAL;
            end
          end
          MODE_GAUSS: begin
            div_start    = 1'b1;
            div_dividend = CntW'(gsum_r);
            div_divisor  = DimW'(gn_r);
            state_nxt    = BK_DIVVAL;
          end
          MODE_SOBEL: begin
            res_nxt   = ValW'(gx_abs) + ValW'(gy_abs);
            state_nxt = BK_OUT;
          end
          default: begin
            res_nxt   = ValW'(center_r);
            state_nxt = BK_OUT;
          end
        endcase
      end
      BK_DIVVAL: begin
        if (div_done) begin
          res_nxt   = div_quo[ValW-1:0];
          state_nxt = BK_OUT;
        end
      end
      BK_OUT: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign out_ch.out_valid     = res_emit_r;
  assign out_ch.out_value     = res_r;
  assign out_ch.out_frame_end = res_end_r;

  // line store, one write or one read per cycle
  always_ff @(posedge clk) begin
    if (state_r == BK_WRITE && job_r.wr_en) mem[job_r.wr_addr] <= job_r.wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    job_r       <= job_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    pend_pres_r <= pend_pres_nxt;
    pend_k_r    <= pend_k_nxt;
    msum_r      <= msum_nxt;
    mn_r        <= mn_nxt;
    gsum_r      <= gsum_nxt;
    gn_r        <= gn_nxt;
    gx_r        <= gx_nxt;
    gy_r        <= gy_nxt;
    center_r    <= center_nxt;
    res_r       <= res_nxt;
    res_emit_r  <= res_emit_nxt;
    res_end_r   <= res_end_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      ki_r     <= '0;
      kj_r     <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ki_r     <= ki_nxt;
      kj_r     <= kj_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/image_3x3_window_filter.sv =====
// top level of the 3x3 window image filter
//
//  channel   dir   handshake         payload
//  in_ch     in    valid / ready     pixel_valid, pixel_value[7:0]
//  out_ch    out   valid / ready     out_valid, out_value[10:0], out_frame_end
//  cfg_*     in    cfg_we            cfg_index[1:0], cfg_wdata[10:0]
//
// every accepted item gives exactly one result item, in order
// back end steps per item: IDLE, WRITE and OUT when no pixel is filtered; a filtered
//   pixel adds the row/column split on the serial divider, the nine tap reads and CALC,
//   and mean (unless neighbourless) and gaussian add a second divide for the quotient
// the front end takes one item per cycle while the 4-entry job queue has room
// synchronous active-low reset clears counters, queue and control; the line
//   store is not cleared, every entry is written before it is read
// out_ch stalls hold the result register; the front keeps queueing meanwhile
`default_nettype none
module image_3x3_window_filter (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  i3wf_in_if.sink                            in_ch,
  i3wf_out_if.source                         out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [i3wf_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [i3wf_pkg::DimW-1:0]     cfg_wdata
);
  import i3wf_pkg::*;

  // configuration registers
  logic [DimW-1:0] width_r, width_nxt;
  logic [DimW-1:0] height_r, height_nxt;
  mode_t           mode_r, mode_nxt;
  cfg_t            cfg;

  // front to queue, queue to back
  job_t push_data, pop_data;
  logic push_valid, push_ready, pop_valid, pop_ready;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    mode_nxt   = mode_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  width_nxt  = cfg_wdata;
        REG_FRAME_HEIGHT: height_nxt = cfg_wdata;
        REG_FILTER_MODE:  mode_nxt   = mode_t'(cfg_wdata[ModeW-1:0]);
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DimW'(640);
      height_r <= DimW'(480);
      mode_r   <= MODE_PASS;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      mode_r   <= mode_nxt;
    end
  end

  assign cfg.width  = width_r;
  assign cfg.height = height_r;
  assign cfg.mode   = mode_r;

  // front: frame bookkeeping, decides which centre each item releases
  i3wf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // short queue so front and back stall independently
  i3wf_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  // back: store write, window gather, arithmetic and result register
  i3wf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_data  (pop_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire
